// ===== design/jjn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjn_pkg
// Constants, codes and kernel tables of the error-diffusion dither.
// ----------------------------------------------------------------------------
package jjn_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int PALETTE_DEPTH = 256;
  localparam int WIN_DEPTH     = 2 * MAX_WIDTH + 3;
  localparam int WIN_AW        = $clog2(WIN_DEPTH);
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int DIVISOR       = 48;
  // floor(x * RECIP / 2**RECIP_SH) equals x / DIVISOR for 0 <= x <= 255 * 7
  localparam int RECIP_SH      = 16;
  localparam int RECIP         = (1 << RECIP_SH) / DIVISOR + 1;
  localparam logic [17:0] DIST_INIT = 18'(255 * 255 * 3 + 1);

  // item kinds
  localparam logic [1:0] MODE_PALETTE = 2'd0;
  localparam logic [1:0] MODE_PIXEL   = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;

  // register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_PALETTE_SIZE = 1'b1;

  // kernel walked as 15 taps: row = tap / 5, column offset = tap % 5 - 2
  localparam logic [3:0] TAP_LAST = 4'd14;

  typedef logic [7:0] chan_t;

  function automatic logic [2:0] tap_weight(input logic [3:0] tap);
    case (tap)
      4'd3:    tap_weight = 3'd7;
      4'd4:    tap_weight = 3'd5;
      4'd5:    tap_weight = 3'd3;
      4'd6:    tap_weight = 3'd5;
      4'd7:    tap_weight = 3'd7;
      4'd8:    tap_weight = 3'd5;
      4'd9:    tap_weight = 3'd3;
      4'd10:   tap_weight = 3'd1;
      4'd11:   tap_weight = 3'd3;
      4'd12:   tap_weight = 3'd5;
      4'd13:   tap_weight = 3'd3;
      4'd14:   tap_weight = 3'd1;
      default: tap_weight = 3'd0;
    endcase
  endfunction

  function automatic logic [1:0] tap_row(input logic [3:0] tap);
    if (tap < 4'd5) tap_row = 2'd0;
    else if (tap < 4'd10) tap_row = 2'd1;
    else tap_row = 2'd2;
  endfunction

  // column offset -2..2 as signed 3 bits
  function automatic logic signed [2:0] tap_dcol(input logic [3:0] tap);
    logic [3:0] m;
    if (tap < 4'd5) m = tap;
    else if (tap < 4'd10) m = tap - 4'd5;
    else m = tap - 4'd10;
    tap_dcol = 3'(signed'({1'b0, m[2:0]}) - 4'sd2);
  endfunction

endpackage

// ===== design/jjn_error_diffusion_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jjn_error_diffusion_dither
// Jarvis-Judice-Ninke error diffusion of an RGB raster to a loaded palette.
// ----------------------------------------------------------------------------
//  channel | ports            | payload
//  --------+------------------+----------------------------------------------
//  in      | in_t*            | palette load, pixel or flush request
//  out     | out_t*           | palette index of the oldest pending pixel
//  cfg     | cfg_we/addr/wdata| image_width (0), palette_size (1)
//
// A palette load, a pixel that only enters the window and an empty flush are
// completed in ST_IDLE. A request that processes a pixel reads it from the
// window, then makes one palette read per cycle for the nearest-colour search,
// then one check step for each of the 15 kernel taps and one write step per
// in-frame neighbour on the single window memory port pair. in_tready is low
// while a request is at work and while a finished result cannot be loaded into
// the output register. Reset clears the control state and counters and sets
// image_width to 640 and palette_size to 256; memories need no clearing.
module jjn_error_diffusion_dither
  import jjn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  logic [2:0]  in_tuser,   // mode[1:0], frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // color_index
  output logic        out_tlast,  // end_of_frame
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PIXRD  = 4'd1;
  localparam logic [3:0] ST_PIXLAT = 4'd2;
  localparam logic [3:0] ST_SEARCH = 4'd3;
  localparam logic [3:0] ST_PALRD  = 4'd4;
  localparam logic [3:0] ST_ERR    = 4'd5;
  localparam logic [3:0] ST_NCHK   = 4'd6;
  localparam logic [3:0] ST_NUPD   = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;
  localparam logic [3:0] ST_WRPIX  = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;

  // configuration
  logic [10:0] image_width_r;
  logic [8:0]  palette_size_r;
  logic [10:0] eff_w;
  logic [8:0]  eff_n;
  logic [11:0] lag;

  // memories
  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] win_mem [WIN_DEPTH];
  logic [23:0] pal_rd_r, win_rd_r;
  logic [PAL_AW-1:0] pal_raddr;
  logic [WIN_AW-1:0] win_raddr, win_waddr;
  logic [23:0] win_wdata;
  logic        win_we, pal_we;

  // control
  logic [3:0]  state_r, state_nxt;
  logic [11:0] pending_r, pending_nxt;
  logic [WIN_AW-1:0] head_r, head_nxt;
  logic [10:0] col_r, col_nxt;
  logic        eof_r, eof_nxt;
  logic        late_wr_r, late_wr_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        pal_vld_r, pal_vld_nxt;
  logic [3:0]  tap_r, tap_nxt;
  logic        out_valid_r, out_valid_nxt;

  // datapath
  logic [23:0] pix_r, pix_nxt;
  logic [23:0] hold_r, hold_nxt;
  logic [PAL_AW-1:0] cand_r, cand_nxt;
  logic [PAL_AW-1:0] best_r, best_nxt;
  logic [17:0] bestd_r, bestd_nxt;
  logic signed [8:0] err_r [3];
  logic signed [8:0] err_nxt [3];
  logic [WIN_AW-1:0] nidx_r, nidx_nxt;
  logic [2:0]  nwt_r, nwt_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  // request fields
  logic [1:0]  in_mode;
  logic        in_fs;
  logic [7:0]  in_entry;
  logic [23:0] in_rgb;
  logic        in_fire;

  assign in_mode  = in_tuser[1:0];
  assign in_fs    = in_tuser[2];
  assign in_entry = in_tdata[7:0];
  assign in_rgb   = in_tdata[31:8];
  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // clamp register values into their working ranges
  always_comb begin
    if (image_width_r == 11'd0) eff_w = 11'd1;
    else if (image_width_r > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
    else eff_w = image_width_r;
    if (palette_size_r == 9'd0) eff_n = 9'd1;
    else if (palette_size_r > 9'(PALETTE_DEPTH)) eff_n = 9'(PALETTE_DEPTH);
    else eff_n = palette_size_r;
    lag = {eff_w, 1'b0} + 12'd2;
  end

  // squared distance of the pixel to the palette word just read
  logic [17:0] cand_dist;
  always_comb begin
    logic signed [17:0] e;
    logic [17:0] sq;
    cand_dist = '0;
    for (int c = 0; c < 3; c++) begin
      e = 18'(signed'({1'b0, pix_r[8*c +: 8]}) - signed'({1'b0, pal_rd_r[8*c +: 8]}));
      sq = unsigned'(e * e);
      cand_dist = cand_dist + sq;
    end
  end

  // neighbour of the current tap: bounds and window address
  logic               tap_ok;
  logic [WIN_AW-1:0]  tap_idx;
  always_comb begin
    logic signed [12:0] nx;
    logic signed [12:0] off;
    logic [12:0]        sum;
    logic [1:0]         row;
    row = tap_row(tap_r);
    nx  = signed'({2'b00, col_r}) + 13'(tap_dcol(tap_r));
    case (row)
      2'd0:    off = 13'(tap_dcol(tap_r));
      2'd1:    off = signed'({2'b00, eff_w}) + 13'(tap_dcol(tap_r));
      default: off = signed'({1'b0, eff_w, 1'b0}) + 13'(tap_dcol(tap_r));
    endcase
    tap_ok = (tap_weight(tap_r) != 3'd0) && (nx >= 0) && (nx < signed'({2'b00, eff_w}))
             && (off > 0) && (off < signed'({1'b0, pending_r}));
    sum = 13'(head_r) + unsigned'(off);
    if (sum >= 13'(WIN_DEPTH)) sum = sum - 13'(WIN_DEPTH);
    tap_idx = sum[WIN_AW-1:0];
  end

  // diffused neighbour value: add err*w/48 per channel, truncate toward zero, clamp
  logic [23:0] upd;
  always_comb begin
    logic [10:0] mag;
    logic [21:0] prod;
    logic [5:0]  q;
    logic signed [9:0] nv;
    upd = '0;
    for (int c = 0; c < 3; c++) begin
      mag  = 11'(unsigned'(err_r[c] < 0 ? -err_r[c] : err_r[c])) * 11'(nwt_r);
      prod = 22'(mag) * 22'(RECIP);
      q    = prod[RECIP_SH +: 6];
      if (err_r[c] < 0) nv = signed'({2'b00, win_rd_r[8*c +: 8]}) - signed'({4'b0, q});
      else nv = signed'({2'b00, win_rd_r[8*c +: 8]}) + signed'({4'b0, q});
      if (nv < 0) upd[8*c +: 8] = 8'd0;
      else if (nv > 10'sd255) upd[8*c +: 8] = 8'd255;
      else upd[8*c +: 8] = nv[7:0];
    end
  end

  // window slot after the last pending pixel
  function automatic logic [WIN_AW-1:0] tail_of(input logic [WIN_AW-1:0] h,
                                                input logic [11:0] p);
    logic [12:0] s;
    s = 13'(h) + 13'(p);
    if (s >= 13'(WIN_DEPTH)) s = s - 13'(WIN_DEPTH);
    if (s >= 13'(WIN_DEPTH)) s = s - 13'(WIN_DEPTH);
    return s[WIN_AW-1:0];
  endfunction

  // sequencer
  always_comb begin
    logic [11:0] p0;
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    head_nxt      = head_r;
    col_nxt       = col_r;
    eof_nxt       = eof_r;
    late_wr_nxt   = late_wr_r;
    cnt_nxt       = cnt_r;
    pal_vld_nxt   = pal_vld_r;
    tap_nxt       = tap_r;
    out_valid_nxt = out_valid_r;
    pix_nxt       = pix_r;
    hold_nxt      = hold_r;
    cand_nxt      = cand_r;
    best_nxt      = best_r;
    bestd_nxt     = bestd_r;
    err_nxt       = err_r;
    nidx_nxt      = nidx_r;
    nwt_nxt       = nwt_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pal_raddr     = cnt_r[PAL_AW-1:0];
    win_raddr     = head_r;
    win_waddr     = tail_of(head_r, pending_r);
    win_wdata     = hold_r;
    win_we        = 1'b0;
    pal_we        = 1'b0;
    p0            = pending_r;

    // drop the result once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_PALETTE: begin
              pal_we = 1'b1;
            end
            MODE_PIXEL: begin
              eof_nxt  = 1'b0;
              hold_nxt = in_rgb;
              if (in_fs) begin
                p0 = '0;
                head_nxt = '0;
                col_nxt = '0;
              end
              pending_nxt = p0;
              if (p0 >= 12'(WIN_DEPTH)) begin
                // window full: process first, then store the pixel
                late_wr_nxt = 1'b1;
                state_nxt = ST_PIXRD;
              end else begin
                late_wr_nxt = 1'b0;
                win_we = 1'b1;
                win_waddr = tail_of(in_fs ? '0 : head_r, p0);
                win_wdata = in_rgb;
                pending_nxt = p0 + 12'd1;
                if (p0 + 12'd1 > lag) state_nxt = ST_PIXRD;
              end
            end
            MODE_FLUSH: begin
              eof_nxt = 1'b1;
              late_wr_nxt = 1'b0;
              if (pending_r != 12'd0) state_nxt = ST_PIXRD;
            end
            default: ;
          endcase
        end
      end
      ST_PIXRD: begin
        win_raddr = head_r;
        state_nxt = ST_PIXLAT;
      end
      ST_PIXLAT: begin
        pix_nxt     = win_rd_r;
        cnt_nxt     = '0;
        pal_vld_nxt = 1'b0;
        bestd_nxt   = DIST_INIT;
        best_nxt    = '0;
        state_nxt   = ST_SEARCH;
      end
      ST_SEARCH: begin
        // one palette read issued and one distance compared per cycle
        if (pal_vld_r && cand_dist < bestd_r) begin
          bestd_nxt = cand_dist;
          best_nxt  = cand_r;
        end
        if (cnt_r < eff_n) begin
          pal_raddr   = cnt_r[PAL_AW-1:0];
          cand_nxt    = cnt_r[PAL_AW-1:0];
          pal_vld_nxt = 1'b1;
          cnt_nxt     = cnt_r + 9'd1;
        end else begin
          pal_vld_nxt = 1'b0;
          if (!pal_vld_r) state_nxt = ST_PALRD;
        end
      end
      ST_PALRD: begin
        pal_raddr = best_r;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        for (int c = 0; c < 3; c++) begin
          err_nxt[c] = signed'({1'b0, pix_r[8*c +: 8]}) - signed'({1'b0, pal_rd_r[8*c +: 8]});
        end
        tap_nxt   = '0;
        state_nxt = ST_NCHK;
      end
      ST_NCHK: begin
        if (tap_ok) begin
          win_raddr = tap_idx;
          nidx_nxt  = tap_idx;
          nwt_nxt   = tap_weight(tap_r);
          state_nxt = ST_NUPD;
        end else if (tap_r == TAP_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          tap_nxt = tap_r + 4'd1;
        end
      end
      ST_NUPD: begin
        win_we    = 1'b1;
        win_waddr = nidx_r;
        win_wdata = upd;
        if (tap_r == TAP_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          tap_nxt   = tap_r + 4'd1;
          state_nxt = ST_NCHK;
        end
      end
      ST_FIN: begin
        // advance the window past the processed pixel
        head_nxt = (head_r == WIN_AW'(WIN_DEPTH - 1)) ? '0 : head_r + 1'b1;
        pending_nxt = pending_r - 12'd1;
        col_nxt = (col_r + 11'd1 >= eff_w) ? '0 : col_r + 11'd1;
        state_nxt = late_wr_r ? ST_WRPIX : ST_EMIT;
      end
      ST_WRPIX: begin
        win_we      = 1'b1;
        win_waddr   = tail_of(head_r, pending_r);
        win_wdata   = hold_r;
        pending_nxt = pending_r + 12'd1;
        late_wr_nxt = 1'b0;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free, then load the result
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'(best_r);
          out_last_nxt  = eof_r && (pending_r == 12'd0);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[in_entry[PAL_AW-1:0]] <= in_rgb;
    pal_rd_r <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rd_r <= win_mem[win_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pending_r      <= '0;
      head_r         <= '0;
      col_r          <= '0;
      eof_r          <= 1'b0;
      late_wr_r      <= 1'b0;
      cnt_r          <= '0;
      pal_vld_r      <= 1'b0;
      tap_r          <= '0;
      out_valid_r    <= 1'b0;
      image_width_r  <= 11'd640;
      palette_size_r <= 9'd256;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      head_r      <= head_nxt;
      col_r       <= col_nxt;
      eof_r       <= eof_nxt;
      late_wr_r   <= late_wr_nxt;
      cnt_r       <= cnt_nxt;
      pal_vld_r   <= pal_vld_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
          CFG_PALETTE_SIZE: palette_size_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    hold_r     <= hold_nxt;
    cand_r     <= cand_nxt;
    best_r     <= best_nxt;
    bestd_r    <= bestd_nxt;
    err_r      <= err_nxt;
    nidx_r     <= nidx_nxt;
    nwt_r      <= nwt_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
